### rtl/rc4_pkg.sv
// Package: shared types, codes and state encoding for the RC4 cipher engine.
package rc4_pkg;

    typedef logic [7:0] byte_t;

    // command codes
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_DATA  = 2'd0;
    localparam logic [1:0] STATUS_KEYED = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam byte_t LAST_INDEX = 8'hFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_W1,
        ST_KS_W2,
        ST_PR_J,
        ST_PR_W1,
        ST_PR_W2,
        ST_OUT
    } state_t;

    // write request into the permutation table
    typedef struct packed {
        logic  en;
        byte_t addr;
        byte_t data;
    } sbox_wr_t;

endpackage

### rtl/rc4_if.sv
// Interfaces: input and result channels of the RC4 cipher engine.
interface rc4_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] byte_in;
    logic       last;

    modport source (output valid, output command, output byte_in, output last, input ready);
    modport sink (input valid, input command, input byte_in, input last, output ready);
endinterface

interface rc4_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last_out;
    logic [1:0] status;

    modport source (output valid, output byte_out, output last_out, output status, input ready);
    modport sink (input valid, input byte_out, input last_out, input status, output ready);
endinterface

### rtl/rc4_sbox_ram.sv
// Permutation table: 256 x 8 memory, one write port, one registered read port.
module rc4_sbox_ram (
    input  logic               clk,
    input  rc4_pkg::sbox_wr_t  wr,
    input  rc4_pkg::byte_t     raddr,
    output rc4_pkg::byte_t     rdata
);

    rc4_pkg::byte_t mem [256];
    rc4_pkg::byte_t rdata_reg;

    // read returns the old contents when the same entry is written in the same cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rc4_stream_cipher_top.sv
// RC4 cipher engine: key store, sequencer and permutation table with one read and one write port.
// Data transaction: states PR_J, PR_W1, PR_W2 and OUT; next input is taken back in IDLE, once the result loads.
// Key transaction without last: byte stored, state stays IDLE, no result.
// Final key transaction: fill of all 256 table entries, then 256 schedule steps through KS_RD, KS_J, KS_W1, KS_W2.
// Both sequences are set by the single read and single write port of the permutation table.
// Reset (rst_n low, async) clears indices, key count, keyed flag and the result valid flag.
module rc4_stream_cipher_top #(
    parameter int KEY_CAPACITY = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    rc4_in_if.sink          in_ch,
    rc4_out_if.source       out_ch
);

    localparam int KEY_AW = (KEY_CAPACITY > 1) ? $clog2(KEY_CAPACITY) : 1;
    localparam int KEY_CW = $clog2(KEY_CAPACITY + 1);

    rc4_pkg::state_t   state_reg, state_next;
    rc4_pkg::byte_t    i_reg, i_next;
    rc4_pkg::byte_t    j_reg, j_next;
    rc4_pkg::byte_t    n_reg, n_next;
    rc4_pkg::byte_t    si_reg, si_next;
    rc4_pkg::byte_t    sj_reg, sj_next;
    rc4_pkg::byte_t    t_reg, t_next;
    rc4_pkg::byte_t    data_reg, data_next;
    logic              last_reg, last_next;
    logic [KEY_AW-1:0] kidx_reg, kidx_next;
    logic [KEY_CW-1:0] key_count_reg, key_count_next;
    logic              keyed_reg, keyed_next;

    rc4_pkg::byte_t    res_byte_reg, res_byte_next;
    logic              res_last_reg, res_last_next;
    logic [1:0]        res_status_reg, res_status_next;

    logic              out_valid_reg, out_valid_next;
    rc4_pkg::byte_t    out_byte_reg;
    logic              out_last_reg;
    logic [1:0]        out_status_reg;
    logic              out_load;

    rc4_pkg::sbox_wr_t sbox_wr;
    rc4_pkg::byte_t    sbox_raddr;
    rc4_pkg::byte_t    sbox_rdata;

    rc4_pkg::byte_t    key_mem [KEY_CAPACITY];
    rc4_pkg::byte_t    key_rd_reg;
    logic              key_we;

    logic              accept;
    logic              key_room;
    logic [KEY_CW-1:0] key_count_inc;
    logic [KEY_CW-1:0] kidx_inc;
    rc4_pkg::byte_t    ks_byte;
    rc4_pkg::byte_t    j_sum;

    rc4_sbox_ram u_sbox (
        .clk   (clk),
        .wr    (sbox_wr),
        .raddr (sbox_raddr),
        .rdata (sbox_rdata)
    );

    assign in_ch.ready     = (state_reg == rc4_pkg::ST_IDLE);
    assign accept          = in_ch.valid && in_ch.ready;
    assign key_room        = (key_count_reg < KEY_CW'(KEY_CAPACITY));
    assign key_count_inc   = key_count_reg + KEY_CW'(key_room);
    assign kidx_inc        = KEY_CW'(kidx_reg) + KEY_CW'(1);
    assign key_we          = accept && (in_ch.command == rc4_pkg::CMD_KEY) && key_room;

    assign out_load        = (state_reg == rc4_pkg::ST_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        t_next          = t_reg;
        data_next       = data_reg;
        last_next       = last_reg;
        kidx_next       = kidx_reg;
        key_count_next  = key_count_reg;
        keyed_next      = keyed_reg;
        res_byte_next   = res_byte_reg;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        sbox_wr         = '0;
        sbox_raddr      = n_reg;
        ks_byte         = sbox_rdata;
        j_sum           = j_reg + sbox_rdata + key_rd_reg;

        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.command == rc4_pkg::CMD_KEY)
                    begin
                        key_count_next = key_count_inc;
                        if (in_ch.last)
                        begin
                            if (key_count_inc == '0)
                            begin
                                res_byte_next   = '0;
                                res_last_next   = 1'b0;
                                res_status_next = rc4_pkg::STATUS_ERROR;
                                state_next      = rc4_pkg::ST_OUT;
                            end
                            else
                            begin
                                n_next     = '0;
                                state_next = rc4_pkg::ST_FILL;
                            end
                        end
                    end
                    else if (!keyed_reg)
                    begin
                        res_byte_next   = '0;
                        res_last_next   = in_ch.last;
                        res_status_next = rc4_pkg::STATUS_ERROR;
                        state_next      = rc4_pkg::ST_OUT;
                    end
                    else
                    begin
                        i_next     = i_reg + 8'd1;
                        sbox_raddr = i_reg + 8'd1;
                        data_next  = in_ch.byte_in;
                        last_next  = in_ch.last;
                        state_next = rc4_pkg::ST_PR_J;
                    end
                end
            end

            rc4_pkg::ST_PR_J:
            begin
                si_next    = sbox_rdata;
                j_next     = j_reg + sbox_rdata;
                sbox_raddr = j_reg + sbox_rdata;
                state_next = rc4_pkg::ST_PR_W1;
            end

            rc4_pkg::ST_PR_W1:
            begin
                sj_next    = sbox_rdata;
                sbox_wr    = '{en: 1'b1, addr: i_reg, data: sbox_rdata};
                sbox_raddr = si_reg + sbox_rdata;
                t_next     = si_reg + sbox_rdata;
                state_next = rc4_pkg::ST_PR_W2;
            end

            rc4_pkg::ST_PR_W2:
            begin
                sbox_wr = '{en: 1'b1, addr: j_reg, data: si_reg};
                // keystream read overlapped the swap writes: forward the new entries
                if (t_reg == j_reg)
                begin
                    ks_byte = si_reg;
                end
                else if (t_reg == i_reg)
                begin
                    ks_byte = sj_reg;
                end
                res_byte_next   = data_reg ^ ks_byte;
                res_last_next   = last_reg;
                res_status_next = rc4_pkg::STATUS_DATA;
                state_next      = rc4_pkg::ST_OUT;
            end

            rc4_pkg::ST_FILL:
            begin
                sbox_wr = '{en: 1'b1, addr: n_reg, data: n_reg};
                n_next  = n_reg + 8'd1;
                if (n_reg == rc4_pkg::LAST_INDEX)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = rc4_pkg::ST_KS_RD;
                end
            end

            rc4_pkg::ST_KS_RD:
            begin
                sbox_raddr = n_reg;
                state_next = rc4_pkg::ST_KS_J;
            end

            rc4_pkg::ST_KS_J:
            begin
                si_next    = sbox_rdata;
                j_next     = j_sum;
                sbox_raddr = j_sum;
                state_next = rc4_pkg::ST_KS_W1;
            end

            rc4_pkg::ST_KS_W1:
            begin
                sbox_wr    = '{en: 1'b1, addr: n_reg, data: sbox_rdata};
                state_next = rc4_pkg::ST_KS_W2;
            end

            rc4_pkg::ST_KS_W2:
            begin
                sbox_wr   = '{en: 1'b1, addr: j_reg, data: si_reg};
                n_next    = n_reg + 8'd1;
                // key index runs modulo the key length
                kidx_next = (kidx_inc == key_count_reg) ? '0 : kidx_inc[KEY_AW-1:0];
                if (n_reg == rc4_pkg::LAST_INDEX)
                begin
                    i_next          = '0;
                    j_next          = '0;
                    key_count_next  = '0;
                    keyed_next      = 1'b1;
                    res_byte_next   = '0;
                    res_last_next   = 1'b0;
                    res_status_next = rc4_pkg::STATUS_KEYED;
                    state_next      = rc4_pkg::ST_OUT;
                end
                else
                begin
                    state_next = rc4_pkg::ST_KS_RD;
                end
            end

            rc4_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            kidx_reg      <= '0;
            key_count_reg <= '0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            kidx_reg      <= kidx_next;
            key_count_reg <= key_count_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg         <= si_next;
        sj_reg         <= sj_next;
        t_reg          <= t_next;
        data_reg       <= data_next;
        last_reg       <= last_next;
        res_byte_reg   <= res_byte_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_byte_reg   <= res_byte_reg;
            out_last_reg   <= res_last_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_count_reg[KEY_AW-1:0]] <= in_ch.byte_in;
        end
        key_rd_reg <= key_mem[kidx_reg];
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.byte_out = out_byte_reg;
    assign out_ch.last_out = out_last_reg;
    assign out_ch.status   = out_status_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KEY_CW'(KEY_CAPACITY))
        else $error("key count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_KS_RD) |-> (KEY_CW'(kidx_reg) < key_count_reg))
        else $error("key index outside stored key");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_FILL && n_reg == rc4_pkg::LAST_INDEX)
        |=> (state_reg == rc4_pkg::ST_KS_RD && j_reg == '0 && n_reg == '0))
        else $error("schedule did not start cleanly after table fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_OUT && res_status_reg == rc4_pkg::STATUS_DATA) |-> keyed_reg)
        else $error("data result without a scheduled key");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rc4_pkg::ST_OUT && res_status_reg == rc4_pkg::STATUS_KEYED)
        |-> (keyed_reg && i_reg == '0 && j_reg == '0 && key_count_reg == '0))
        else $error("key schedule finished without clearing indices");
`endif

endmodule

### tb/sv/rc4_stream_cipher_top_tb.sv
`timescale 1ns / 1ps
// Testbench for the RC4 cipher engine: directed table, random key/data streams, keystream model.
module rc4_stream_cipher_top_tb;

    localparam int KEY_CAP      = 256;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 26;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        rc4_pkg::byte_t byte_out;
        logic           last_out;
        logic [1:0]     status;
    } result_t;

    typedef struct packed {
        logic           command;
        rc4_pkg::byte_t data;
        logic           last;
        logic           fixed;
        result_t        want;
    } vector_t;

    localparam result_t NO_RESULT = '0;
    localparam result_t NOT_KEYED = '{8'h00, 1'b0, rc4_pkg::STATUS_ERROR};
    localparam result_t NOT_KEYED_LAST = '{8'h00, 1'b1, rc4_pkg::STATUS_ERROR};
    localparam result_t KEY_DONE = '{8'h00, 1'b0, rc4_pkg::STATUS_KEYED};

    localparam int N_DIRECTED = 22;
    localparam vector_t DIRECTED [N_DIRECTED] = '{
        '{rc4_pkg::CMD_DATA, 8'h00, 1'b0, 1'b1, NOT_KEYED},      // data before any key
        '{rc4_pkg::CMD_DATA, 8'hFF, 1'b1, 1'b1, NOT_KEYED_LAST},
        '{rc4_pkg::CMD_KEY,  8'h4B, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'hA5, 1'b0, 1'b1, NOT_KEYED},      // key under way, still no table
        '{rc4_pkg::CMD_KEY,  8'h65, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_KEY,  8'h79, 1'b1, 1'b1, KEY_DONE},
        '{rc4_pkg::CMD_DATA, 8'h50, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h6C, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h61, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h69, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h6E, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h74, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h65, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h78, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h74, 1'b1, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_KEY,  8'h00, 1'b1, 1'b1, KEY_DONE},       // one-byte key
        '{rc4_pkg::CMD_DATA, 8'h00, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'hFF, 1'b1, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_KEY,  8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{rc4_pkg::CMD_DATA, 8'h3C, 1'b0, 1'b0, NO_RESULT},      // old key still in use
        '{rc4_pkg::CMD_KEY,  8'h80, 1'b1, 1'b1, KEY_DONE},
        '{rc4_pkg::CMD_DATA, 8'h7E, 1'b1, 1'b0, NO_RESULT}
    };

    logic clk = 1'b0;
    logic rst_n;

    rc4_in_if  in_ch ();
    rc4_out_if out_ch ();

    rc4_stream_cipher_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // keystream model state
    rc4_pkg::byte_t perm [256];
    rc4_pkg::byte_t key_mem [256];
    int             key_len = 0;
    rc4_pkg::byte_t idx_i = '0;
    rc4_pkg::byte_t idx_j = '0;
    logic           keyed = 1'b0;

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      items_done = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;

    function automatic logic rc4_predict(input logic command, input rc4_pkg::byte_t data,
                                         input logic last, output result_t res);
        rc4_pkg::byte_t j;
        rc4_pkg::byte_t t;
        rc4_pkg::byte_t ks;
        res = '0;
        if (command == rc4_pkg::CMD_KEY)
        begin
            if (key_len < KEY_CAP)
            begin
                key_mem[key_len] = data;
                key_len++;
            end
            if (!last)
                return 1'b0;
            if (key_len == 0)
            begin
                res.status = rc4_pkg::STATUS_ERROR;
                return 1'b1;
            end
            for (int n = 0; n < 256; n++)
                perm[n] = rc4_pkg::byte_t'(n);
            j = '0;
            for (int n = 0; n < 256; n++)
            begin
                j = j + perm[n] + key_mem[n % key_len];
                t = perm[n];
                perm[n] = perm[j];
                perm[j] = t;
            end
            idx_i = '0;
            idx_j = '0;
            key_len = 0;
            keyed = 1'b1;
            res.status = rc4_pkg::STATUS_KEYED;
            return 1'b1;
        end
        res.last_out = last;
        if (!keyed)
        begin
            res.status = rc4_pkg::STATUS_ERROR;
            return 1'b1;
        end
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + perm[idx_i];
        t = perm[idx_i];
        perm[idx_i] = perm[idx_j];
        perm[idx_j] = t;
        ks = perm[rc4_pkg::byte_t'(perm[idx_i] + perm[idx_j])];
        res.byte_out = data ^ ks;
        res.status = rc4_pkg::STATUS_DATA;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task automatic send_item(input logic command, input rc4_pkg::byte_t data, input logic last,
                             input logic fixed, input result_t want);
        result_t res;
        logic    has_res;
        while (!quiet && $urandom_range(99, 0) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= command;
        in_ch.byte_in <= data;
        in_ch.last    <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // key bytes past capacity without last are simply dropped
        if (!(command == rc4_pkg::CMD_KEY && key_len >= KEY_CAP && !last))
            items_done++;
        has_res = rc4_predict(command, data, last, res);
        if (has_res)
            pending_results.push_back(fixed ? want : res);
    endtask

    task automatic send_key(input int len);
        for (int k = 0; k < len; k++)
            send_item(rc4_pkg::CMD_KEY, rc4_pkg::byte_t'($urandom), k == len - 1, 1'b0,
                      NO_RESULT);
    endtask

    task automatic send_data(input int len);
        for (int k = 0; k < len; k++)
            send_item(rc4_pkg::CMD_DATA, rc4_pkg::byte_t'($urandom),
                      (k == len - 1) || ($urandom_range(15, 0) == 0), 1'b0, NO_RESULT);
    endtask

    always @(posedge clk)
        out_ch.ready <= quiet || ($urandom_range(99, 0) >= IDLE_PCT);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result transaction with nothing expected");
            else
            begin
                want = pending_results.pop_front();
                check_field("byte_out", out_ch.byte_out, want.byte_out);
                check_field("last_out", out_ch.last_out, want.last_out);
                check_field("status", out_ch.status, want.status);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int  seq;
        int  len;
        int  pick;
        bit  paused;
        logic cmd;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.command <= rc4_pkg::CMD_KEY;
        in_ch.byte_in <= '0;
        in_ch.last    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_item(DIRECTED[r].command, DIRECTED[r].data, DIRECTED[r].last,
                      DIRECTED[r].fixed, DIRECTED[r].want);

        items_done = 0;
        seq = 0;
        paused = 1'b0;
        while (items_done < RANDOM_ITEMS)
        begin
            quiet = (items_done >= 400 && items_done < 700);
            if (!paused && items_done >= 900)
            begin
                paused = 1'b1;
                in_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            // first two keys overrun and exactly fill the key store
            if (seq == 0)
                len = 300;
            else if (seq == 1)
                len = KEY_CAP;
            else if ($urandom_range(15, 0) == 0)
                len = $urandom_range(300, 200);
            else
                len = $urandom_range(24, 1);
            pick = (seq < 2) ? 99 : $urandom_range(99, 0);
            if (pick < 10)
            begin
                repeat ($urandom_range(8, 1))
                begin
                    cmd = 1'($urandom_range(1, 0));
                    send_item(cmd, rc4_pkg::byte_t'($urandom),
                              (cmd == rc4_pkg::CMD_KEY) ? ($urandom_range(7, 0) == 0)
                                                        : logic'($urandom_range(1, 0)),
                              1'b0, NO_RESULT);
                end
            end
            else if (pick < 22)
            begin
                // new key half loaded while data still runs on the old table
                repeat (len) send_item(rc4_pkg::CMD_KEY, rc4_pkg::byte_t'($urandom), 1'b0,
                                       1'b0, NO_RESULT);
                send_data($urandom_range(20, 1));
                send_item(rc4_pkg::CMD_KEY, rc4_pkg::byte_t'($urandom), 1'b1, 1'b0, NO_RESULT);
                send_data($urandom_range(60, 1));
            end
            else
            begin
                send_key(len);
                send_data($urandom_range(60, 1));
            end
            seq++;
        end
        quiet = 1'b0;
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
rtl/rc4_pkg.sv
rtl/rc4_if.sv
rtl/rc4_sbox_ram.sv
rtl/rc4_stream_cipher_top.sv
tb/sv/rc4_stream_cipher_top_tb.sv
